### design/mfs_pkg.sv
// Shared types, constants and lookup tables of the MP3 frame sync scanner.
`timescale 1ns / 1ps

package mfs_pkg;

   // Scan limit and the byte counter that must be able to hold it
   localparam int MAX_SCAN = 65536;
   localparam int CNT_W    = $clog2(MAX_SCAN + 1);

   // Payload widths
   localparam int KBPS_W   = 9;
   localparam int RATE_W   = 16;
   localparam int FRAME_W  = 11;
   localparam int SPF_W    = 11;
   localparam int COEF_W   = 18;

   // Divider sizing: dividend = coef * kbps stays below 2^26, quotient below 2^11
   localparam int DIVIDEND_W = 26;
   localparam int Q_W        = FRAME_W;
   localparam int STEP_W     = $clog2(Q_W);

   // Header fields
   localparam logic [31:0] SYNC_MASK = 32'hFFE0_0000;
   localparam logic [1:0]  VER_25    = 2'd0;
   localparam logic [1:0]  VER_RES   = 2'd1;
   localparam logic [1:0]  VER_2     = 2'd2;
   localparam logic [1:0]  VER_1     = 2'd3;
   localparam logic [1:0]  LAYER_III = 2'b01;
   localparam logic [3:0]  BIDX_FREE = 4'd0;
   localparam logic [3:0]  BIDX_BAD  = 4'd15;
   localparam logic [1:0]  SIDX_RES  = 2'd3;
   localparam logic [1:0]  MODE_MONO = 2'd3;

   localparam logic [COEF_W-1:0] COEF_V1 = 18'd144000;
   localparam logic [COEF_W-1:0] COEF_V2 = 18'd72000;
   localparam logic [SPF_W-1:0]  SPF_V1  = 11'd1152;
   localparam logic [SPF_W-1:0]  SPF_V2  = 11'd576;

   // Register map
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_SCAN_BASE = 1'b0;

   // Decoded header
   typedef struct packed {
      logic                  valid;
      logic [1:0]            version;
      logic [KBPS_W-1:0]     kbps;
      logic [RATE_W-1:0]     rate;
      logic [DIVIDEND_W-1:0] dividend;
      logic [SPF_W-1:0]      spf;
      logic                  mono;
      logic                  crc;
      logic                  pad;
   } hdr_info_type;

   // Result word
   typedef struct packed {
      logic               found;
      logic [31:0]        offset;
      logic [1:0]         version;
      logic [KBPS_W-1:0]  kbps;
      logic [RATE_W-1:0]  rate;
      logic [FRAME_W-1:0] frame_len;
      logic [SPF_W-1:0]   spf;
      logic               mono;
      logic               crc;
   } rsp_type;

   // Bitrate in kbps for a bitrate index; v1 selects the MPEG1 table
   function automatic logic [KBPS_W-1:0] kbps_lookup(input logic v1, input logic [3:0] bidx);
      logic [KBPS_W-1:0] k;
      k = '0;
      if (v1) begin
         unique case (bidx)
            4'd1:    k = 9'd32;
            4'd2:    k = 9'd40;
            4'd3:    k = 9'd48;
            4'd4:    k = 9'd56;
            4'd5:    k = 9'd64;
            4'd6:    k = 9'd80;
            4'd7:    k = 9'd96;
            4'd8:    k = 9'd112;
            4'd9:    k = 9'd128;
            4'd10:   k = 9'd160;
            4'd11:   k = 9'd192;
            4'd12:   k = 9'd224;
            4'd13:   k = 9'd256;
            4'd14:   k = 9'd320;
            default: k = '0;
         endcase
      end else begin
         unique case (bidx)
            4'd1:    k = 9'd8;
            4'd2:    k = 9'd16;
            4'd3:    k = 9'd24;
            4'd4:    k = 9'd32;
            4'd5:    k = 9'd40;
            4'd6:    k = 9'd48;
            4'd7:    k = 9'd56;
            4'd8:    k = 9'd64;
            4'd9:    k = 9'd80;
            4'd10:   k = 9'd96;
            4'd11:   k = 9'd112;
            4'd12:   k = 9'd128;
            4'd13:   k = 9'd144;
            4'd14:   k = 9'd160;
            default: k = '0;
         endcase
      end
      return k;
   endfunction

   // MPEG1 sample rate for a sample-rate index
   function automatic logic [RATE_W-1:0] base_rate(input logic [1:0] sidx);
      logic [RATE_W-1:0] r;
      unique case (sidx)
         2'd0:    r = 16'd44100;
         2'd1:    r = 16'd48000;
         2'd2:    r = 16'd32000;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

### design/mfs_header_decode.sv
// Frame header check and field decode for one four-byte window.
`timescale 1ns / 1ps

module mfs_header_decode (
   input  logic [31:0]          hdr,
   output mfs_pkg::hdr_info_type info
);

   logic [1:0]                          ver;
   logic [1:0]                          layer;
   logic [3:0]                          bidx;
   logic [1:0]                          sidx;
   logic [mfs_pkg::RATE_W-1:0]          rate0;
   logic [mfs_pkg::COEF_W-1:0]          coef;
   logic [mfs_pkg::KBPS_W-1:0]          kbps;
   logic [mfs_pkg::COEF_W+mfs_pkg::KBPS_W-1:0] prod;

   assign ver   = hdr[20:19];
   assign layer = hdr[18:17];
   assign bidx  = hdr[15:12];
   assign sidx  = hdr[11:10];

   // Table lookups
   assign kbps  = mfs_pkg::kbps_lookup(ver == mfs_pkg::VER_1, bidx);
   assign rate0 = mfs_pkg::base_rate(sidx);
   assign coef  = (ver == mfs_pkg::VER_1) ? mfs_pkg::COEF_V1 : mfs_pkg::COEF_V2;
   assign prod  = coef * kbps;

   always_comb begin
      info.valid = ((hdr & mfs_pkg::SYNC_MASK) == mfs_pkg::SYNC_MASK)
                   && (ver != mfs_pkg::VER_RES) && (layer == mfs_pkg::LAYER_III)
                   && (bidx != mfs_pkg::BIDX_FREE) && (bidx != mfs_pkg::BIDX_BAD)
                   && (sidx != mfs_pkg::SIDX_RES);
      info.version = ver;
      info.kbps    = kbps;
      // halved for MPEG2, quartered for MPEG2.5
      priority if (ver == mfs_pkg::VER_2) begin
         info.rate = rate0 >> 1;
      end else if (ver == mfs_pkg::VER_25) begin
         info.rate = rate0 >> 2;
      end else begin
         info.rate = rate0;
      end
      info.dividend = prod[mfs_pkg::DIVIDEND_W-1:0];
      info.spf      = (ver == mfs_pkg::VER_1) ? mfs_pkg::SPF_V1 : mfs_pkg::SPF_V2;
      info.mono     = (hdr[7:6] == mfs_pkg::MODE_MONO);
      info.crc      = ~hdr[16];
      info.pad      = hdr[9];
   end

endmodule

### design/mfs_divider.sv
// Restoring divider, one quotient bit per cycle, for the frame length.
`timescale 1ns / 1ps

module mfs_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [mfs_pkg::DIVIDEND_W-1:0]    dividend,
   input  logic [mfs_pkg::RATE_W-1:0]        divisor,
   output logic                              done,
   output logic [mfs_pkg::Q_W-1:0]           quotient
);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [mfs_pkg::STEP_W-1:0]     step_ff, step_in;
   logic [mfs_pkg::DIVIDEND_W-1:0] rem_ff, rem_in;
   logic [mfs_pkg::DIVIDEND_W-1:0] dsh_ff, dsh_in;
   logic [mfs_pkg::Q_W-1:0]        quo_ff, quo_in;
   logic                           fits;

   // Shared compare / subtract
   assign fits = rem_ff >= dsh_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      if (start) begin
         // quotient always fits Q_W bits, so start at the top quotient bit
         busy_in = 1'b1;
         step_in = mfs_pkg::STEP_W'(mfs_pkg::Q_W - 1);
         rem_in  = dividend;
         dsh_in  = mfs_pkg::DIVIDEND_W'(divisor) << (mfs_pkg::Q_W - 1);
         quo_in  = '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - dsh_ff;
         end
         quo_in = {quo_ff[mfs_pkg::Q_W-2:0], fits};
         dsh_in = dsh_ff >> 1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quo_ff  <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### design/mp3_frame_sync_scanner.sv
// Top level: byte window, scan control, result register and CSR port.
// Results: a byte that ends the scan without a header shows its result the cycle after it
// is taken; a byte that completes a header shows it once the 11-step shift-subtract divider
// has computed the frame length and the result register has been loaded.
// Throughput: one byte per cycle while scanning and the result register is free.
// Reset (synchronous) clears the window, count, done flag, scan_base and all valid flags.
`timescale 1ns / 1ps

module mp3_frame_sync_scanner (
   input  logic                               clock,
   input  logic                               reset,
   // input bytes
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [7:0]                         req_data_byte,
   input  logic                               req_new_scan,
   input  logic                               req_scan_end,
   // results
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_found,
   output logic [31:0]                        rsp_offset,
   output logic [1:0]                         rsp_version_code,
   output logic [mfs_pkg::KBPS_W-1:0]         rsp_kbps,
   output logic [mfs_pkg::RATE_W-1:0]         rsp_rate_hz,
   output logic [mfs_pkg::FRAME_W-1:0]        rsp_frame_len,
   output logic [mfs_pkg::SPF_W-1:0]          rsp_frame_samples,
   output logic                               rsp_mono,
   output logic                               rsp_crc_present,
   // configuration
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [mfs_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);

   typedef enum logic {ST_SCAN, ST_DIV} state_type;

   state_type                   state_ff, state_in;
   logic [23:0]                 window_ff, window_in;
   logic [mfs_pkg::CNT_W-1:0]   count_ff, count_in;
   logic                        done_ff, done_in;
   logic [31:0]                 base_ff, base_in;
   logic                        pad_ff, pad_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   mfs_pkg::rsp_type            rsp_ff, rsp_in;

   logic                        accept;
   logic                        csr_wr;
   logic [23:0]                 win_eff;
   logic [mfs_pkg::CNT_W-1:0]   cnt_eff;
   logic [mfs_pkg::CNT_W-1:0]   cnt_new;
   logic                        done_eff;
   logic [31:0]                 hdr;
   logic                        match;
   logic                        div_start;
   logic                        div_done;
   logic [mfs_pkg::Q_W-1:0]     div_q;
   mfs_pkg::hdr_info_type       info;

   assign req_ready = (state_ff == ST_SCAN) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign csr_wr    = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Window as seen by this word: a scan start clears it first
   assign win_eff  = req_new_scan ? 24'd0 : window_ff;
   assign cnt_eff  = req_new_scan ? '0 : count_ff;
   assign done_eff = req_new_scan ? 1'b0 : done_ff;
   assign cnt_new  = cnt_eff + 1'b1;
   assign hdr      = {win_eff, req_data_byte};

   mfs_header_decode u_decode (
      .hdr  (hdr),
      .info (info)
   );

   assign match     = info.valid && (cnt_new >= mfs_pkg::CNT_W'(4));
   assign div_start = accept && !done_eff && match;

   mfs_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (info.dividend),
      .divisor  (info.rate),
      .done     (div_done),
      .quotient (div_q)
   );

   // Next-state logic
   always_comb begin
      state_in     = state_ff;
      window_in    = window_ff;
      count_in     = count_ff;
      done_in      = done_ff;
      base_in      = base_ff;
      pad_in       = pad_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (csr_wr && (csr_paddr[2] == mfs_pkg::CSR_IDX_SCAN_BASE)) begin
         base_in = csr_pwdata;
      end

      unique case (state_ff)
         ST_SCAN: begin
            if (accept) begin
               window_in = win_eff;
               count_in  = cnt_eff;
               done_in   = done_eff;
               if (!done_eff) begin
                  window_in = hdr[23:0];
                  count_in  = cnt_new;
                  if (match) begin
                     // header found: load fields, length comes from the divider
                     done_in             = 1'b1;
                     state_in            = ST_DIV;
                     pad_in              = info.pad;
                     rsp_in.found        = 1'b1;
                     rsp_in.offset       = base_ff + 32'(cnt_new) - 32'd4;
                     rsp_in.version      = info.version;
                     rsp_in.kbps         = info.kbps;
                     rsp_in.rate         = info.rate;
                     rsp_in.frame_len    = '0;
                     rsp_in.spf          = info.spf;
                     rsp_in.mono         = info.mono;
                     rsp_in.crc          = info.crc;
                  end else if (req_scan_end
                               || (cnt_new >= mfs_pkg::CNT_W'(mfs_pkg::MAX_SCAN))) begin
                     // not found: all fields zero
                     done_in      = 1'b1;
                     rsp_in       = '0;
                     rsp_valid_in = 1'b1;
                  end
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               rsp_in.frame_len = div_q + mfs_pkg::FRAME_W'(pad_ff);
               rsp_valid_in     = 1'b1;
               state_in         = ST_SCAN;
            end
         end
         default: state_in = ST_SCAN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SCAN;
         window_ff    <= '0;
         count_ff     <= '0;
         done_ff      <= 1'b0;
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         count_ff     <= count_in;
         done_ff      <= done_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pad_ff <= pad_in;
      rsp_ff <= rsp_in;
   end

   // Outputs
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_ff.found;
   assign rsp_offset        = rsp_ff.offset;
   assign rsp_version_code  = rsp_ff.version;
   assign rsp_kbps          = rsp_ff.kbps;
   assign rsp_rate_hz       = rsp_ff.rate;
   assign rsp_frame_len     = rsp_ff.frame_len;
   assign rsp_frame_samples = rsp_ff.spf;
   assign rsp_mono          = rsp_ff.mono;
   assign rsp_crc_present   = rsp_ff.crc;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == mfs_pkg::CSR_IDX_SCAN_BASE) ? base_ff : 32'd0;

   // Checks
   a_no_input_while_dividing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> !req_ready)
      else $error("input taken while divider busy");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside divide state");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_offset == 32'd0 && rsp_kbps == '0
                                     && rsp_frame_len == '0))
      else $error("not-found word carries nonzero fields");

endmodule

### sim/tb.sv
// Testbench for the MP3 frame sync scanner: directed table, random scans, predictor checks.
`timescale 1ns / 1ps

module tb;

   // Register address of scan_base
   localparam logic [mfs_pkg::CSR_ADDR_W-1:0] SCAN_BASE_ADDR =
      mfs_pkg::CSR_ADDR_W'(4 * mfs_pkg::CSR_IDX_SCAN_BASE);

   // Bitrate and sample-rate tables, indexed by the header fields
   localparam logic [mfs_pkg::KBPS_W-1:0] KBPS_MPEG1 [16] = '{
      9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112, 9'd128,
      9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
   localparam logic [mfs_pkg::KBPS_W-1:0] KBPS_MPEG2 [16] = '{
      9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80,
      9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};
   localparam logic [mfs_pkg::RATE_W-1:0] RATE_MPEG1 [4] =
      '{16'd44100, 16'd48000, 16'd32000, 16'd0};

   // Results that can be read off the header at a glance
   localparam mfs_pkg::rsp_type NOT_FOUND = '0;
   localparam mfs_pkg::rsp_type FOUND_FIRST = '{found: 1'b1, offset: 32'd0,
      version: mfs_pkg::VER_1, kbps: 9'd128, rate: 16'd44100, frame_len: 11'd417,
      spf: mfs_pkg::SPF_V1, mono: 1'b0, crc: 1'b0};
   localparam mfs_pkg::rsp_type FOUND_LONGEST = '{found: 1'b1, offset: 32'd15,
      version: mfs_pkg::VER_1, kbps: 9'd320, rate: 16'd32000, frame_len: 11'd1441,
      spf: mfs_pkg::SPF_V1, mono: 1'b1, crc: 1'b1};

   // Ways to spoil a header
   typedef enum int {FLAW_SYNC, FLAW_VERSION, FLAW_LAYER, FLAW_BITRATE, FLAW_RATE} flaw_type;

   typedef struct packed {
      logic [7:0]       data;
      logic             start;
      logic             last;
      logic             typed_on;
      mfs_pkg::rsp_type typed;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid, req_ready, req_new_scan, req_scan_end;
   logic [7:0] req_data_byte;
   logic rsp_valid, rsp_ready, rsp_found, rsp_mono, rsp_crc_present;
   logic [31:0] rsp_offset;
   logic [1:0] rsp_version_code;
   logic [mfs_pkg::KBPS_W-1:0] rsp_kbps;
   logic [mfs_pkg::RATE_W-1:0] rsp_rate_hz;
   logic [mfs_pkg::FRAME_W-1:0] rsp_frame_len;
   logic [mfs_pkg::SPF_W-1:0] rsp_frame_samples;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [mfs_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;

   // Predictor state
   logic [23:0]               sync_window;
   logic [mfs_pkg::CNT_W-1:0] scan_count;
   logic                      scan_finished;
   logic [31:0]               scan_base_shadow;

   mfs_pkg::rsp_type pending_results [$];
   dir_row_type      dir_rows [25];
   int               error_count = 0;
   int               live_items = 0;
   int               hold_cycles = 0;
   bit               gaps_on = 1'b1;

   mp3_frame_sync_scanner u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data_byte(req_data_byte),
      .req_new_scan(req_new_scan), .req_scan_end(req_scan_end),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_found(rsp_found),
      .rsp_offset(rsp_offset), .rsp_version_code(rsp_version_code),
      .rsp_kbps(rsp_kbps), .rsp_rate_hz(rsp_rate_hz),
      .rsp_frame_len(rsp_frame_len), .rsp_frame_samples(rsp_frame_samples),
      .rsp_mono(rsp_mono), .rsp_crc_present(rsp_crc_present),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s: got 'h%0h, expected 'h%0h", name, got, want));
      end
   endtask

   // Scan predictor: takes one input word, returns -1 if ignored, else the result count
   function automatic int advance_scan(input logic [7:0] b, input logic s, input logic e,
                                       output mfs_pkg::rsp_type res);
      logic [31:0]                hdr;
      logic [1:0]                 ver, layer, sidx;
      logic [3:0]                 bidx;
      logic [mfs_pkg::KBPS_W-1:0] kbps;
      logic [mfs_pkg::RATE_W-1:0] rate;
      logic [63:0]                dividend;
      res = '0;
      if (s) begin
         sync_window = '0;
         scan_count = '0;
         scan_finished = 1'b0;
      end
      if (scan_finished) return -1;
      scan_count++;
      hdr = {sync_window, b};
      ver = hdr[20:19];
      layer = hdr[18:17];
      bidx = hdr[15:12];
      sidx = hdr[11:10];
      if (scan_count >= 4 && (hdr & mfs_pkg::SYNC_MASK) == mfs_pkg::SYNC_MASK &&
          ver != mfs_pkg::VER_RES && layer == mfs_pkg::LAYER_III &&
          bidx != mfs_pkg::BIDX_FREE && bidx != mfs_pkg::BIDX_BAD &&
          sidx != mfs_pkg::SIDX_RES) begin
         kbps = (ver == mfs_pkg::VER_1) ? KBPS_MPEG1[bidx] : KBPS_MPEG2[bidx];
         // MPEG2 halves the rate, MPEG2.5 quarters it
         rate = RATE_MPEG1[sidx] >> ((ver == mfs_pkg::VER_1) ? 0 :
                                     (ver == mfs_pkg::VER_2) ? 1 : 2);
         dividend = 64'((ver == mfs_pkg::VER_1) ? mfs_pkg::COEF_V1 : mfs_pkg::COEF_V2) * kbps;
         res.found = 1'b1;
         res.offset = scan_base_shadow + 32'(scan_count) - 32'd4;
         res.version = ver;
         res.kbps = kbps;
         res.rate = rate;
         res.frame_len = mfs_pkg::FRAME_W'(dividend / rate + hdr[9]);
         res.spf = (ver == mfs_pkg::VER_1) ? mfs_pkg::SPF_V1 : mfs_pkg::SPF_V2;
         res.mono = (hdr[7:6] == mfs_pkg::MODE_MONO);
         res.crc = !hdr[16];
         scan_finished = 1'b1;
         sync_window = hdr[23:0];
         return 1;
      end
      sync_window = hdr[23:0];
      if (e || scan_count >= mfs_pkg::MAX_SCAN) begin
         scan_finished = 1'b1;
         return 1;
      end
      return 0;
   endfunction

   // Random header, well formed or with one flaw
   function automatic logic [31:0] make_header(input bit good);
      logic [10:0] sync;
      logic [1:0]  ver, layer, sidx;
      logic [3:0]  bidx;
      int          pick;
      flaw_type    flaw;
      sync = 11'h7FF;
      pick = $urandom_range(2);
      ver = (pick == 0) ? mfs_pkg::VER_25 : (pick == 1) ? mfs_pkg::VER_2 : mfs_pkg::VER_1;
      layer = mfs_pkg::LAYER_III;
      bidx = 4'($urandom_range(14, 1));
      sidx = 2'($urandom_range(2));
      if (!good) begin
         flaw = flaw_type'($urandom_range(4));
         case (flaw)
            FLAW_SYNC:    sync[$urandom_range(10)] = 1'b0;
            FLAW_VERSION: ver = mfs_pkg::VER_RES;
            FLAW_LAYER:   layer = mfs_pkg::LAYER_III ^ 2'($urandom_range(3, 1));
            FLAW_BITRATE: bidx = $urandom_range(1) ? mfs_pkg::BIDX_BAD : mfs_pkg::BIDX_FREE;
            default:      sidx = mfs_pkg::SIDX_RES;
         endcase
      end
      return {sync, ver, layer, 1'($urandom), bidx, sidx, 10'($urandom)};
   endfunction

   // Filler byte, often 0xFF to tease the sync search
   function automatic logic [7:0] noise_byte();
      return ($urandom_range(5) == 0) ? 8'hFF : 8'($urandom);
   endfunction

   // Offer one input word; on acceptance advance the predictor and queue the result
   task automatic send_byte(input logic [7:0] b, input logic s, input logic e,
                            input bit typed_on, input mfs_pkg::rsp_type typed);
      mfs_pkg::rsp_type res;
      int               status;
      @(negedge clock);
      while (gaps_on && $urandom_range(99) < 23) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_new_scan <= s;
      req_scan_end <= e;
      do @(posedge clock); while (!req_ready);
      status = advance_scan(b, s, e, res);
      if (status >= 0) live_items++;
      if (typed_on) pending_results.push_back(typed);
      else if (status > 0) pending_results.push_back(res);
   endtask

   task automatic send_plain(input logic [7:0] b, input logic s, input logic e);
      send_byte(b, s, e, 1'b0, '0);
   endtask

   // One scan: noise, maybe a header, trailing noise, sometimes an end marker
   task automatic random_scan();
      logic [7:0]  bytes [$];
      logic [31:0] hdr;
      int          kind, end_at;
      bit          start_on;
      repeat (($urandom_range(3) == 0) ? $urandom_range(12) : $urandom_range(3))
         bytes.push_back(noise_byte());
      kind = $urandom_range(99);
      if (kind < 85) begin
         hdr = make_header(kind < 70);
         for (int k = 3; k >= 0; k--) bytes.push_back(hdr[8*k +: 8]);
      end
      repeat ($urandom_range(2)) bytes.push_back(noise_byte());
      if (bytes.size() == 0) bytes.push_back(noise_byte());
      end_at = ($urandom_range(9) < 3) ? $urandom_range(bytes.size() - 1) : -1;
      start_on = ($urandom_range(9) != 0);
      for (int i = 0; i < bytes.size(); i++)
         send_plain(bytes[i], start_on && i == 0, i == end_at);
   endtask

   task automatic random_scans(input int n);
      int target;
      target = live_items + n;
      while (live_items < target) random_scan();
   endtask

   // Drop valid, wait for outstanding results and the divider latency
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      for (int n = 0; n < 5000 && pending_results.size() != 0; n++) @(posedge clock);
      repeat (20) @(posedge clock);
      if (pending_results.size() != 0) begin
         report_mismatch($sformatf("%0d expected result words never arrived",
                                   pending_results.size()));
         pending_results.delete();
      end
   endtask

   // APB transfer to scan_base: setup cycle, then access cycle
   task automatic csr_access(input logic wr, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= SCAN_BASE_ADDR;
      csr_pwdata <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic program_scan_base(input logic [31:0] value);
      logic [31:0] rd;
      csr_access(1'b1, value, rd);
      csr_access(1'b0, '0, rd);
      compare_field("scan_base readback", rd, value);
      scan_base_shadow = value;
   endtask

   // Result sink, with a long hold-off on request
   initial begin : result_sink
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_ready <= !(gaps_on && $urandom_range(99) < 23);
         end
      end
   end

   // Result checker
   always @(posedge clock) begin : check_results
      mfs_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result word with no expected result waiting");
         end else begin
            want = pending_results.pop_front();
            compare_field("found", rsp_found, want.found);
            compare_field("offset", rsp_offset, want.offset);
            compare_field("version_code", rsp_version_code, want.version);
            compare_field("kbps", rsp_kbps, want.kbps);
            compare_field("rate_hz", rsp_rate_hz, want.rate);
            compare_field("frame_len", rsp_frame_len, want.frame_len);
            compare_field("frame_samples", rsp_frame_samples, want.spf);
            compare_field("mono", rsp_mono, want.mono);
            compare_field("crc_present", rsp_crc_present, want.crc);
         end
      end
   end

   // Watchdog
   initial begin
      #20_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      logic [31:0] rd;
      logic [31:0] hdr;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = '0;
      req_new_scan = 1'b0;
      req_scan_end = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      sync_window = '0;
      scan_count = '0;
      scan_finished = 1'b0;
      scan_base_shadow = '0;

      // Directed words: header with no new-scan flag after reset, a byte after the
      // result, a short scan, then one scan of near misses ending on the end byte
      dir_rows = '{
         '{8'hFF, 1'b0, 1'b0, 1'b0, NOT_FOUND},
         '{8'hFB, 1'b0, 1'b0, 1'b0, NOT_FOUND},
         '{8'h90, 1'b0, 1'b0, 1'b0, NOT_FOUND},
         '{8'h64, 1'b0, 1'b0, 1'b1, FOUND_FIRST},
         '{8'h00, 1'b0, 1'b0, 1'b0, NOT_FOUND},
         '{8'h00, 1'b1, 1'b1, 1'b1, NOT_FOUND},
         '{8'hFF, 1'b1, 1'b0, 1'b0, NOT_FOUND},
         '{8'hEB, 1'b0, 1'b0, 1'b0, NOT_FOUND},   // reserved version
         '{8'hFF, 1'b0, 1'b0, 1'b0, NOT_FOUND},
         '{8'hFD, 1'b0, 1'b0, 1'b0, NOT_FOUND},
         '{8'h90, 1'b0, 1'b0, 1'b0, NOT_FOUND},
         '{8'h00, 1'b0, 1'b0, 1'b0, NOT_FOUND},   // layer II
         '{8'hFF, 1'b0, 1'b0, 1'b0, NOT_FOUND},
         '{8'hFB, 1'b0, 1'b0, 1'b0, NOT_FOUND},
         '{8'hF0, 1'b0, 1'b0, 1'b0, NOT_FOUND},
         '{8'hFF, 1'b0, 1'b0, 1'b0, NOT_FOUND},   // bitrate index 15
         '{8'hFB, 1'b0, 1'b0, 1'b0, NOT_FOUND},
         '{8'h1C, 1'b0, 1'b0, 1'b0, NOT_FOUND},
         '{8'hFF, 1'b0, 1'b0, 1'b0, NOT_FOUND},   // reserved sample rate
         '{8'hFB, 1'b0, 1'b0, 1'b0, NOT_FOUND},
         '{8'h00, 1'b0, 1'b0, 1'b0, NOT_FOUND},
         '{8'hFF, 1'b0, 1'b0, 1'b0, NOT_FOUND},   // free bitrate
         '{8'hFA, 1'b0, 1'b0, 1'b0, NOT_FOUND},
         '{8'hEA, 1'b0, 1'b0, 1'b0, NOT_FOUND},
         '{8'hFF, 1'b0, 1'b1, 1'b1, FOUND_LONGEST}
      };

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // scan_base after reset
      csr_access(1'b0, '0, rd);
      compare_field("scan_base after reset", rd, 32'd0);

      foreach (dir_rows[i])
         send_byte(dir_rows[i].data, dir_rows[i].start, dir_rows[i].last,
                   dir_rows[i].typed_on, dir_rows[i].typed);
      settle();

      // Random scans, top base so offsets wrap
      program_scan_base(32'hFFFF_FFFF);
      random_scans(80);
      settle();

      // Random base, no idling on either side
      program_scan_base($urandom);
      gaps_on = 1'b0;
      random_scans(80);
      settle();

      // Sink holds off while back-to-back header scans fill the block
      program_scan_base(32'hFFFF_FFF0);
      hold_cycles = 300;
      repeat (25) begin
         hdr = make_header(1'b1);
         for (int k = 3; k >= 0; k--) send_plain(hdr[8*k +: 8], k == 3, 1'b0);
      end
      gaps_on = 1'b1;
      random_scans(80);
      settle();

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
